@@ rtl/core/gbnr_pkg.sv @@
package gbnr_pkg;

  localparam int unsigned BufferSegmentsDefault = 256;
  localparam int unsigned QueueDepthDefault     = 4;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_BYTE   = 2'd1,
    KIND_LAST   = 2'd2
  } item_kind_e;

  typedef enum logic [2:0] {
    VERDICT_ACCEPTED     = 3'd0,
    VERDICT_CORRUPTED    = 3'd1,
    VERDICT_OUT_OF_ORDER = 3'd2,
    VERDICT_BUFFER_FULL  = 3'd3,
    VERDICT_AFTER_FIN    = 3'd4
  } verdict_e;

  // one classified request as it travels from the front through the queue
  typedef struct packed {
    item_kind_e  kind;
    logic [30:0] seq_number;
    logic [31:0] carried_crc;
    logic        fin_flag;
    logic [7:0]  data_byte;
  } item_t;

  // queue status seen by the front
  typedef struct packed {
    logic full;
  } q_status_t;

  // reflected CRC-32, one byte
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                             input logic [7:0]  data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/core/gbnr_front.sv @@
module gbnr_front
  import gbnr_pkg::*;
(
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [30:0] seq_number_i,
  input  logic [31:0] carried_crc_i,
  input  logic        fin_flag_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  q_status_t   q_status_i,
  output logic        push_o,
  output item_t       push_item_o
);

  item_kind_e kind;

  always_comb begin
    if (!command_i) begin
      kind = KIND_HEADER;
    end else if (last_byte_i) begin
      kind = KIND_LAST;
    end else begin
      kind = KIND_BYTE;
    end
  end

  assign in_stall_o = q_status_i.full;
  assign push_o     = in_valid_i & ~q_status_i.full;

  assign push_item_o.kind        = kind;
  assign push_item_o.seq_number  = seq_number_i;
  assign push_item_o.carried_crc = carried_crc_i;
  assign push_item_o.fin_flag    = fin_flag_i;
  assign push_item_o.data_byte   = data_byte_i;

endmodule

@@ rtl/core/gbnr_queue.sv @@
module gbnr_queue
  import gbnr_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  item_t     push_item_i,
  output q_status_t status_o,
  output logic      pop_valid_o,
  output item_t     pop_item_o,
  input  logic      pop_i
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);

  item_t           entry_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_pop;

  assign status_o.full = (cnt_q == CntW'(QUEUE_DEPTH));
  assign pop_valid_o   = (cnt_q != '0);
  assign pop_item_o    = entry_q[rd_ptr_q];
  assign do_pop        = pop_i & pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

@@ rtl/core/gbnr_back.sv @@
module gbnr_back
  import gbnr_pkg::*;
#(
  parameter int unsigned BUFFER_SEGMENTS = BufferSegmentsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  item_t              item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] ack_number_o,
  output logic [2:0]         verdict_o,
  output logic               finack_o,
  output logic               flush_request_o,
  output logic [8:0]         flush_count_o
);

  localparam int unsigned CntW = $clog2(BUFFER_SEGMENTS + 1);
  localparam int unsigned ExtW = (CntW > 9) ? CntW : 9;

  // session state
  logic [31:0]     last_acc_q, last_acc_d;
  logic [CntW-1:0] buf_cnt_q, buf_cnt_d;
  logic [31:0]     crc_acc_q, crc_acc_d;
  logic [30:0]     lat_seq_q, lat_seq_d;
  logic [31:0]     lat_crc_q, lat_crc_d;
  logic            lat_fin_q, lat_fin_d;
  logic            done_q, done_d;

  // output register
  logic            out_valid_q, out_valid_d;
  logic [31:0]     ack_q, ack_d;
  verdict_e        verdict_q, verdict_d;
  logic            finack_q, finack_d;
  logic            flush_q, flush_d;
  logic [8:0]      fcount_q, fcount_d;

  logic            out_free;
  logic            is_last;
  logic [31:0]     crc_next;
  logic [31:0]     expected;
  logic [CntW-1:0] fcount_wide;
  logic [ExtW-1:0] fcount_ext;

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign is_last  = (item_i.kind == KIND_LAST);
  assign pop_o    = item_valid_i & (~is_last | out_free);
  assign crc_next = crc32_byte(crc_acc_q, item_i.data_byte);
  assign expected = last_acc_q + 32'd1;

  always_comb begin
    last_acc_d  = last_acc_q;
    buf_cnt_d   = buf_cnt_q;
    crc_acc_d   = crc_acc_q;
    lat_seq_d   = lat_seq_q;
    lat_crc_d   = lat_crc_q;
    lat_fin_d   = lat_fin_q;
    done_d      = done_q;
    out_valid_d = out_valid_q & out_stall_i;
    ack_d       = ack_q;
    verdict_d   = verdict_q;
    finack_d    = finack_q;
    flush_d     = flush_q;
    fcount_d    = fcount_q;
    fcount_wide = '0;
    fcount_ext  = '0;

    if (pop_o) begin
      case (item_i.kind)
        KIND_HEADER: begin
          if (!done_q) begin
            lat_seq_d = item_i.seq_number;
            lat_crc_d = item_i.carried_crc;
            lat_fin_d = item_i.fin_flag;
            crc_acc_d = ALL_ONES;
          end
        end
        KIND_BYTE: begin
          crc_acc_d = crc_next;
        end
        KIND_LAST: begin
          crc_acc_d = ALL_ONES;
          finack_d  = 1'b0;
          flush_d   = 1'b0;
          if (done_q) begin
            verdict_d = VERDICT_AFTER_FIN;
          end else begin
            // sequence first, then CRC, then buffer room
            if ({1'b0, lat_seq_q} != expected) begin
              verdict_d = VERDICT_OUT_OF_ORDER;
            end else if ((crc_next ^ ALL_ONES) != lat_crc_q) begin
              verdict_d = VERDICT_CORRUPTED;
            end else if (buf_cnt_q < CntW'(BUFFER_SEGMENTS)) begin
              verdict_d  = VERDICT_ACCEPTED;
              buf_cnt_d  = buf_cnt_q + 1'b1;
              last_acc_d = {1'b0, lat_seq_q};
            end else begin
              verdict_d   = VERDICT_BUFFER_FULL;
              flush_d     = 1'b1;
              fcount_wide = buf_cnt_q;
              buf_cnt_d   = '0;
            end
            // fin matching the last accepted number closes the session,
            // retransmitted fin included
            if (lat_fin_q && ({1'b0, lat_seq_q} == last_acc_d)) begin
              finack_d    = 1'b1;
              flush_d     = 1'b1;
              fcount_wide = buf_cnt_d;
              done_d      = 1'b1;
            end
          end
          fcount_ext  = ExtW'(fcount_wide);
          fcount_d    = fcount_ext[8:0];
          ack_d       = last_acc_d;
          out_valid_d = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_acc_q  <= ALL_ONES;
      buf_cnt_q   <= '0;
      crc_acc_q   <= ALL_ONES;
      lat_seq_q   <= '0;
      lat_crc_q   <= '0;
      lat_fin_q   <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      last_acc_q  <= last_acc_d;
      buf_cnt_q   <= buf_cnt_d;
      crc_acc_q   <= crc_acc_d;
      lat_seq_q   <= lat_seq_d;
      lat_crc_q   <= lat_crc_d;
      lat_fin_q   <= lat_fin_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ack_q     <= ack_d;
    verdict_q <= verdict_d;
    finack_q  <= finack_d;
    flush_q   <= flush_d;
    fcount_q  <= fcount_d;
  end

  assign out_valid_o     = out_valid_q;
  assign ack_number_o    = $signed(ack_q);
  assign verdict_o       = verdict_q;
  assign finack_o        = finack_q;
  assign flush_request_o = flush_q;
  assign flush_count_o   = fcount_q;

endmodule

@@ rtl/core/go_back_n_receiver_unit.sv @@
// Go-Back-N receiver with CRC-32 payload check.
// Input channel (in_valid_i / in_stall_o): one request per header item
// (command_i = 0: seq_number_i, carried_crc_i, fin_flag_i) or payload byte
// (command_i = 1: data_byte_i, last_byte_i marks the segment's final byte).
// Output channel (out_valid_o / out_stall_i): one acknowledgment per segment,
// produced by the final byte: ack_number_o, verdict_o, finack_o,
// flush_request_o, flush_count_o.
// Throughput: one request per cycle while in_stall_o is low. The CRC update
// of one byte and the verdict compares are combinational in the back end.
// Path: a final byte passes the request queue, then the output register,
// before its acknowledgment shows.
// Reset: last accepted number -1, buffer count 0, CRC all ones, latched
// header cleared, session open, queue and output empty.
// Stall: while out_stall_i holds a result, the back end keeps consuming
// header and non-final byte requests; a final byte waits in the queue, and
// once the queue fills in_stall_o rises.
module go_back_n_receiver_unit
  import gbnr_pkg::*;
#(
  parameter int unsigned BUFFER_SEGMENTS = BufferSegmentsDefault,
  parameter int unsigned QUEUE_DEPTH     = QueueDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               command_i,
  input  logic [30:0]        seq_number_i,
  input  logic [31:0]        carried_crc_i,
  input  logic               fin_flag_i,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] ack_number_o,
  output logic [2:0]         verdict_o,
  output logic               finack_o,
  output logic               flush_request_o,
  output logic [8:0]         flush_count_o
);

  q_status_t q_status;
  logic      push;
  item_t     push_item;
  logic      pop;
  logic      pop_valid;
  item_t     pop_item;

  // front: classify request into header / byte / final byte
  gbnr_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .seq_number_i  (seq_number_i),
    .carried_crc_i (carried_crc_i),
    .fin_flag_i    (fin_flag_i),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .q_status_i    (q_status),
    .push_o        (push),
    .push_item_o   (push_item)
  );

  // short queue decoupling intake from judging
  gbnr_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .status_o    (q_status),
    .pop_valid_o (pop_valid),
    .pop_item_o  (pop_item),
    .pop_i       (pop)
  );

  // back: CRC, session state, verdict and output register
  gbnr_back #(
    .BUFFER_SEGMENTS (BUFFER_SEGMENTS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (pop_valid),
    .item_i          (pop_item),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .ack_number_o    (ack_number_o),
    .verdict_o       (verdict_o),
    .finack_o        (finack_o),
    .flush_request_o (flush_request_o),
    .flush_count_o   (flush_count_o)
  );

endmodule

@@ dv/go_back_n_receiver_unit_tb.sv @@
module go_back_n_receiver_unit_tb
  import gbnr_pkg::*;
;

  // Capacity of the segment buffer in the default build of the block
  localparam int unsigned SegCapacity = BufferSegmentsDefault;
  // Soft stop for the random part; it also keeps going until an overflow is seen
  localparam int unsigned RandomRequests = 950;
  localparam int unsigned RequestCap     = 4000;

  // One input request, all fields; the fields that a request does not use still carry noise
  typedef struct packed {
    logic        command;
    logic [30:0] seq;
    logic [31:0] crc;
    logic        fin;
    logic [7:0]  data;
    logic        last;
  } seg_req_t;

  // One acknowledgment as it leaves the block
  typedef struct packed {
    logic signed [31:0] ack_number;
    verdict_e           verdict;
    logic               finack;
    logic               flush;
    logic [8:0]         flush_count;
  } ack_t;

  // A row of the directed table: a request, plus a typed-in ack where one is easy to read off
  typedef struct {
    seg_req_t req;
    bit       typed;
    ack_t     want;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               command_i;
  logic [30:0]        seq_number_i;
  logic [31:0]        carried_crc_i;
  logic               fin_flag_i;
  logic [7:0]         data_byte_i;
  logic               last_byte_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [31:0] ack_number_o;
  logic [2:0]         verdict_o;
  logic               finack_o;
  logic               flush_request_o;
  logic [8:0]         flush_count_o;

  go_back_n_receiver_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .seq_number_i   (seq_number_i),
    .carried_crc_i  (carried_crc_i),
    .fin_flag_i     (fin_flag_i),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .ack_number_o   (ack_number_o),
    .verdict_o      (verdict_o),
    .finack_o       (finack_o),
    .flush_request_o(flush_request_o),
    .flush_count_o  (flush_count_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Receiver state as the testbench sees it; advanced once per accepted request
  // ---------------------------------------------------------------------------
  logic [31:0] rx_last_seq  = ALL_ONES;  // last accepted number, -1 before any
  int unsigned rx_buf_count = 0;         // segments buffered since the last flush
  logic [31:0] rx_crc       = ALL_ONES;  // running CRC over the current payload
  logic [30:0] hdr_seq      = '0;        // header fields latched by the last header
  logic [31:0] hdr_crc      = '0;
  logic        hdr_fin      = 1'b0;
  bit          rx_closed    = 1'b0;      // set once the fin has been acknowledged

  ack_t pending_acks[$];                 // acks predicted but not yet seen
  int   n_errors    = 0;
  int   n_sent      = 0;
  int   n_checked   = 0;
  int   verdict_seen[5] = '{default: 0};
  bit   calm        = 1'b0;              // no idling on either side while set

  // Bit-serial reflected CRC-32, one byte, LSB first
  function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
    for (int i = 0; i < 8; i++) begin
      if (crc[0] ^ b[i]) crc = (crc >> 1) ^ CRC_POLY;
      else               crc = crc >> 1;
    end
    return crc;
  endfunction

  // Applies one request to the receiver state; returns 1 and the ack when the
  // request closes a segment (a final payload byte)
  function automatic bit judge_request(input seg_req_t r, output ack_t a);
    logic [31:0] next_seq;
    a = '0;
    if (!r.command) begin
      // headers after the session end change nothing
      if (!rx_closed) begin
        hdr_seq = r.seq;
        hdr_crc = r.crc;
        hdr_fin = r.fin;
        rx_crc  = ALL_ONES;
      end
      return 1'b0;
    end
    rx_crc = crc_update(rx_crc, r.data);
    if (!r.last) return 1'b0;
    if (rx_closed) begin
      a.verdict = VERDICT_AFTER_FIN;
    end else begin
      next_seq = rx_last_seq + 32'd1;
      // sequence first, then CRC, then buffer room
      if ({1'b0, hdr_seq} != next_seq) begin
        a.verdict = VERDICT_OUT_OF_ORDER;
      end else if (~rx_crc != hdr_crc) begin
        a.verdict = VERDICT_CORRUPTED;
      end else if (rx_buf_count < SegCapacity) begin
        a.verdict    = VERDICT_ACCEPTED;
        rx_buf_count = rx_buf_count + 1;
        rx_last_seq  = {1'b0, hdr_seq};
      end else begin
        // overflow: hand on everything buffered, number stays put
        a.verdict     = VERDICT_BUFFER_FULL;
        a.flush       = 1'b1;
        a.flush_count = rx_buf_count[8:0];
        rx_buf_count  = 0;
      end
      // fin equal to the last accepted number closes the session, also for a
      // retransmitted fin that was just judged out of order
      if (hdr_fin && {1'b0, hdr_seq} == rx_last_seq) begin
        a.finack      = 1'b1;
        a.flush       = 1'b1;
        a.flush_count = rx_buf_count[8:0];
        rx_closed     = 1'b1;
      end
    end
    rx_crc       = ALL_ONES;
    a.ack_number = rx_last_seq;
    return 1'b1;
  endfunction

  function automatic seg_req_t hdr(input logic [30:0] seq, input logic [31:0] crc,
                                   input logic fin);
    seg_req_t r;
    r.command = 1'b0;
    r.seq     = seq;
    r.crc     = crc;
    r.fin     = fin;
    r.data    = 8'($urandom);  // unused on a header
    r.last    = 1'($urandom);
    return r;
  endfunction

  function automatic seg_req_t byt(input logic [7:0] data, input logic last);
    seg_req_t r;
    r.command = 1'b1;
    r.seq     = 31'($urandom); // unused on a payload byte
    r.crc     = $urandom;
    r.fin     = 1'($urandom);
    r.data    = data;
    r.last    = last;
    return r;
  endfunction

  function automatic ack_t ack_of(input logic signed [31:0] num, input verdict_e v);
    ack_t a;
    a            = '0;
    a.ack_number = num;
    a.verdict    = v;
    return a;
  endfunction

  // Gap before a request: mostly none, some short, a few long
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    n_errors++;
  endtask

  // Drives one request and waits for the block to take it. Valid is only
  // lowered when a gap is inserted, so it never toggles within one step.
  task automatic send_req(input seg_req_t r, input bit typed = 1'b0,
                          input ack_t want = '0);
    int   gap;
    ack_t a;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= r.command;
    seq_number_i  <= r.seq;
    carried_crc_i <= r.crc;
    fin_flag_i    <= r.fin;
    data_byte_i   <= r.data;
    last_byte_i   <= r.last;
    do @(posedge clk_i); while (in_stall_o);
    n_sent++;
    if (judge_request(r, a)) begin
      if (typed) a = want;
      pending_acks.push_back(a);
      verdict_seen[int'(a.verdict)]++;
    end
  endtask

  // Sends a segment of n random bytes. The carried CRC is the true one with
  // crc_flip applied; without a header the bytes ride on the latched one, and
  // without close the final byte is never marked.
  task automatic send_segment(input bit with_header, input logic [30:0] seq,
                              input logic [31:0] crc_flip, input bit fin,
                              input int n, input bit close);
    logic [7:0]  pay[$];
    logic [31:0] c;
    c = ALL_ONES;
    for (int i = 0; i < n; i++) begin
      pay.push_back(8'($urandom));
      c = crc_update(c, pay[i]);
    end
    if (with_header) send_req(hdr(seq, ~c ^ crc_flip, fin));
    foreach (pay[i]) send_req(byt(pay[i], close && i == n - 1));
  endtask

  // ---------------------------------------------------------------------------
  // Ack side: random stalls, and every taken ack is compared with the oldest
  // prediction
  // ---------------------------------------------------------------------------
  initial begin : ack_sink
    int   hold;
    ack_t exp_ack;
    hold        = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        n_checked++;
        if (pending_acks.size() == 0) begin
          report_mismatch($sformatf("ack with nothing pending: num %0d verdict %0d",
                                    ack_number_o, verdict_o));
        end else begin
          exp_ack = pending_acks.pop_front();
          if (ack_number_o !== exp_ack.ack_number)
            report_mismatch($sformatf("ack_number got %0d want %0d",
                                      ack_number_o, exp_ack.ack_number));
          if (verdict_o !== exp_ack.verdict)
            report_mismatch($sformatf("verdict got %0d want %0d",
                                      verdict_o, exp_ack.verdict));
          if (finack_o !== exp_ack.finack)
            report_mismatch($sformatf("finack got %b want %b", finack_o, exp_ack.finack));
          if (flush_request_o !== exp_ack.flush)
            report_mismatch($sformatf("flush_request got %b want %b",
                                      flush_request_o, exp_ack.flush));
          if (flush_count_o !== exp_ack.flush_count)
            report_mismatch($sformatf("flush_count got %0d want %0d",
                                      flush_count_o, exp_ack.flush_count));
        end
      end
      // stalls: random holds of out_stall_i; now and then a long one
      // backs requests up into the input queue
      if (hold == 0 && !calm && $urandom_range(0, 99) < 30)
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        hold--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side: directed table, random segments, closing fin, after-fin
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t    dir_table[22];
    int          kind;
    int          n;
    int          seg_idx;
    int          tries;
    int          guard;
    logic [30:0] seq;
    logic [31:0] want_seq;
    logic [31:0] flip;
    bit          fin;

    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    command_i     = 1'b0;
    seq_number_i  = '0;
    carried_crc_i = '0;
    fin_flag_i    = 1'b0;
    data_byte_i   = '0;
    last_byte_i   = 1'b0;

    // Directed: payload before any header, extreme numbers and bytes, a fin
    // that does not match, two acceptances with known CRC-32 values, a header
    // replaced mid-segment, a corrupted fin and a payload with no header
    dir_table = '{
      '{byt(8'h00, 1'b1), 1'b1, ack_of(-1, VERDICT_CORRUPTED)},
      '{hdr(31'd5, 32'h0000_0000, 1'b0), 1'b0, '0},
      '{byt(8'hFF, 1'b1), 1'b1, ack_of(-1, VERDICT_OUT_OF_ORDER)},
      '{hdr(31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1), 1'b0, '0},
      '{byt(8'h80, 1'b1), 1'b1, ack_of(-1, VERDICT_OUT_OF_ORDER)},
      '{hdr(31'd0, 32'hE8B7_BE43, 1'b0), 1'b0, '0},
      '{byt(8'h61, 1'b1), 1'b1, ack_of(0, VERDICT_ACCEPTED)},
      '{hdr(31'd1, 32'h0000_0000, 1'b0), 1'b0, '0},
      '{byt(8'h01, 1'b0), 1'b0, '0},
      '{hdr(31'd1, 32'hCBF4_3926, 1'b0), 1'b0, '0},
      '{byt(8'h31, 1'b0), 1'b0, '0},
      '{byt(8'h32, 1'b0), 1'b0, '0},
      '{byt(8'h33, 1'b0), 1'b0, '0},
      '{byt(8'h34, 1'b0), 1'b0, '0},
      '{byt(8'h35, 1'b0), 1'b0, '0},
      '{byt(8'h36, 1'b0), 1'b0, '0},
      '{byt(8'h37, 1'b0), 1'b0, '0},
      '{byt(8'h38, 1'b0), 1'b0, '0},
      '{byt(8'h39, 1'b1), 1'b1, ack_of(1, VERDICT_ACCEPTED)},
      '{hdr(31'd2, 32'h0000_0000, 1'b1), 1'b0, '0},
      '{byt(8'h31, 1'b1), 1'b1, ack_of(1, VERDICT_CORRUPTED)},
      '{byt(8'h55, 1'b1), 1'b0, '0}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_table[i]) send_req(dir_table[i].req, dir_table[i].typed, dir_table[i].want);

    // Random: mostly well-formed segments with short payloads, so the buffer
    // fills and overflows; the rest out of order, corrupted, orphan payload or
    // segments cut short by the next header. A fin only goes out where it
    // cannot close the session.
    seg_idx = 0;
    while ((n_sent < RandomRequests || verdict_seen[int'(VERDICT_BUFFER_FULL)] == 0) &&
           n_sent < RequestCap) begin
      calm = (seg_idx % 60) < 6;
      kind = $urandom_range(0, 99);
      n    = $urandom_range(0, 99);
      n    = (n < 75) ? 1 : (n < 95) ? $urandom_range(2, 3) : $urandom_range(4, 10);
      want_seq = rx_last_seq + 32'd1;
      seq      = want_seq[30:0];
      if (kind < 10) begin
        case ($urandom_range(0, 2))
          0:       seq = rx_last_seq[30:0];       // retransmission
          1:       seq = want_seq[30:0] + 31'd1;  // one ahead
          default: seq = 31'($urandom);
        endcase
      end
      flip = (kind >= 10 && kind < 20) ? (32'd1 << $urandom_range(0, 31)) : 32'd0;
      fin  = 1'b0;
      if ({1'b0, seq} != rx_last_seq && ({1'b0, seq} != want_seq || flip != 32'd0))
        fin = ($urandom_range(0, 7) == 0);
      send_segment(!(kind >= 90 && kind < 95), seq, flip, fin, n, !(kind >= 95));
      seg_idx++;
    end
    calm = 1'b0;

    // Close the session: either a fresh fin that gets accepted or a
    // retransmitted fin for the number already taken
    tries = 0;
    while (!rx_closed && tries < 4) begin
      if ($urandom_range(0, 1) == 0)
        send_segment(1'b1, rx_last_seq[30:0], $urandom, 1'b1, $urandom_range(1, 3), 1'b1);
      else
        send_segment(1'b1, 31'(rx_last_seq + 32'd1), 32'd0, 1'b1, $urandom_range(1, 3), 1'b1);
      tries++;
    end

    // After the fin: headers are ignored, every segment end reports after-fin
    for (int i = 0; i < 4; i++)
      send_segment(i != 3, 31'(rx_last_seq + 32'd1), 32'd0, 1'($urandom),
                   $urandom_range(1, 3), 1'b1);

    // last request was taken at this edge; drop valid before the next one
    in_valid_i <= 1'b0;

    // Drain: wait for the last acks, then keep watching to catch stray ones
    guard = 0;
    while (pending_acks.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (10) @(posedge clk_i);
    if (pending_acks.size() != 0)
      report_mismatch($sformatf("%0d acks never arrived", pending_acks.size()));

    $display("Run: %0d requests sent, %0d acks checked", n_sent, n_checked);
    $display("Verdicts: accepted %0d, corrupted %0d, out of order %0d, overflow %0d, after fin %0d",
             verdict_seen[0], verdict_seen[1], verdict_seen[2], verdict_seen[3],
             verdict_seen[4]);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #8_000_000;
    $display("Timeout: %0d acks still pending", pending_acks.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
